// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// checked in every cycle, reset included
`define ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ===== rtl/swa_pkg.sv =====
// shared types and constants of the moving average block
package swa_pkg;

  localparam int COUNT_BITS   = 7;
  localparam int AVG_BITS     = 24;
  localparam int WINDOW_RESET = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

// ===== rtl/sliding_window_average_core.sv =====
// top level: each sample is loaded, written to the ring and added to the running sum, then divided
// one sample is in flight at a time: a new sample is taken only after the last result is loaded;
// the restoring divider gives one quotient bit per cycle over sum plus fraction bits
// a finished result waits in the output register; the next sample is taken meanwhile
// rst (synchronous, active high) sets the window to min(64, MAX_WINDOW) and empties ring and sum
// a window_size write clears the filter the same way and takes effect at once
module sliding_window_average_core #(
  parameter int MAX_WINDOW    = 64,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write, no handshake
  input  logic                                window_size_we,
  input  logic [swa_pkg::COUNT_BITS-1:0]      window_size,
  // sample input channel
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  // result output channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [swa_pkg::AVG_BITS-1:0] average,
  output logic [swa_pkg::COUNT_BITS-1:0]      samples_in_window
);

  // command and status between sequencer and datapath
  swa_pkg::cmd_t    cmd;
  swa_pkg::status_t status;

  // sequencer: idle, ring update, divider setup, divide, output hand-off
  swa_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // ring memory, running sum, fill count and single divider
  // unwritten ring slots may be read, but below a full window the old sample is taken as zero
  swa_datapath #(
    .MAX_WINDOW    (MAX_WINDOW),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .window_size_we    (window_size_we),
    .window_size       (window_size),
    .sample            (sample),
    .cmd               (cmd),
    .status            (status),
    .average           (average),
    .samples_in_window (samples_in_window)
  );

endmodule

// ===== rtl/swa_ram.sv =====
// generic single write port ram with registered read
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/swa_controller.sv =====
// sequencing state machine and output valid flag
module swa_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  swa_pkg::status_t status,
  output swa_pkg::cmd_t    cmd
);

  swa_pkg::state_t state, state_next;
  logic result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= swa_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      swa_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = swa_pkg::ST_UPDATE;
        end
      end
      swa_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = swa_pkg::ST_DIV_INIT;
      end
      swa_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = swa_pkg::ST_DIVIDE;
      end
      swa_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = swa_pkg::ST_FINISH;
        end
      end
      swa_pkg::ST_FINISH: begin
        // wait here while the previous result is still held
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

// ===== rtl/swa_datapath.sv =====
// sample ring, running sum, restoring divider and output registers
module swa_datapath #(
  parameter int MAX_WINDOW    = 64,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   window_size_we,
  input  logic [swa_pkg::COUNT_BITS-1:0]         window_size,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  input  swa_pkg::cmd_t                          cmd,
  output swa_pkg::status_t                       status,
  output logic signed [swa_pkg::AVG_BITS-1:0]    average,
  output logic [swa_pkg::COUNT_BITS-1:0]         samples_in_window
);

  localparam int CNT_W    = swa_pkg::COUNT_BITS;
  localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IDX_W    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int DIV_W    = SUM_W + FRACTION_BITS;
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int RES_W    = (DIV_W + 1 > swa_pkg::AVG_BITS) ? DIV_W + 1 : swa_pkg::AVG_BITS;
  localparam int WIN_TOP  = (1 << CNT_W) - 1;
  localparam int WIN_CAP  = (MAX_WINDOW < WIN_TOP) ? MAX_WINDOW : WIN_TOP;
  localparam int WIN_RST  = (swa_pkg::WINDOW_RESET < WIN_CAP) ? swa_pkg::WINDOW_RESET : WIN_CAP;

  logic [CNT_W-1:0]              win, win_eff;
  logic [PTR_W-1:0]              ptr;
  logic [CNT_W-1:0]              fill;
  logic signed [SUM_W-1:0]       sum, sum_next;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic [IDX_W-1:0]              ptr_inc;
  logic [SUM_W-1:0]              mag;
  logic                          neg;
  logic [DIV_W-1:0]              dvd;
  logic [CNT_W-1:0]              rem;
  logic [CNT_W:0]                trial, trial_diff;
  logic                          trial_ge;
  logic [DCNT_W-1:0]             dcnt;
  logic [RES_W-1:0]              quo_ext, res;

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (ptr),
    .wdata (sample_q),
    .raddr (ptr),
    .rdata (rd_data)
  );

  // zero acts as one, anything past the ring depth is clipped
  always_comb begin
    if (window_size == '0) begin
      win_eff = CNT_W'(1);
    end else if (int'(window_size) > WIN_CAP) begin
      win_eff = CNT_W'(WIN_CAP);
    end else begin
      win_eff = window_size;
    end
  end

  // a slot not yet filled since the last clear reads as zero
  assign old_sample = (fill == win) ? $signed(rd_data) : '0;
  assign sum_next   = sum + SUM_W'(sample_q) - SUM_W'(old_sample);
  assign ptr_inc    = IDX_W'(ptr) + IDX_W'(1);
  assign mag        = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign trial      = {rem, dvd[DIV_W-1]};
  assign trial_diff = trial - {1'b0, fill};
  assign trial_ge   = (trial >= {1'b0, fill});

  assign quo_ext = RES_W'(dvd);
  assign res     = neg ? (RES_W'(0) - quo_ext) : quo_ext;

  assign status.div_last = (dcnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= CNT_W'(WIN_RST);
      ptr  <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (window_size_we) begin
      win  <= win_eff;
      ptr  <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (cmd.update) begin
      sum  <= sum_next;
      ptr  <= (ptr_inc >= IDX_W'(win)) ? '0 : ptr_inc[PTR_W-1:0];
      if (fill < win) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample;
    end
    if (cmd.div_init) begin
      neg  <= sum[SUM_W-1];
      dvd  <= DIV_W'(mag) << FRACTION_BITS;
      rem  <= '0;
      dcnt <= DCNT_W'(DIV_W - 1);
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd  <= {dvd[DIV_W-2:0], trial_ge};
      dcnt <= dcnt - DCNT_W'(1);
    end
    if (cmd.out_load) begin
      average           <= $signed(res[swa_pkg::AVG_BITS-1:0]);
      samples_in_window <= fill;
    end
  end

endmodule

// ===== rtl/swa_checker.sv =====
// port level checks for the moving average block and their binding
`include "assert_macros.svh"

module swa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic [swa_pkg::COUNT_BITS-1:0]      samples_in_window
);

  // one sample at a time: no second transfer right after one
  `ASSERT_NEXT(a_one_in_flight, sample_valid && sample_ready, !sample_ready)

  // a result must cover at least one sample
  `ASSERT_IMPLY(a_count_nonzero, result_valid, samples_in_window != '0)

  // a held result stays offered until taken
  `ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)

  // nothing is offered right after reset
  `ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !result_valid)

endmodule

bind sliding_window_average_core swa_checker u_swa_checker (.*);
